// ===== rtl/nnt_pkg.sv =====
// ----------------------------------------------------------------------------
// nnt_pkg - shared definitions for the nearest-neighbor tour block
// Field widths, parameter defaults and the control word of the distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nnt_pkg;

  // Fixed field widths of the ports
  localparam int ID_W    = 16;
  localparam int COORD_W = 16;
  localparam int POS_W   = 6;

  // Defaults for the top level parameters
  localparam int MAX_CITIES_DEF = 32;
  localparam int COORD_BITS_DEF = 16;

  // Control word from the sequencer to the distance unit
  typedef struct packed {
    logic load_diff;  // capture |dx| and |dy| from the store read data
    logic mul_x;      // square dx into the x partial
    logic mul_y;      // square dy into the y partial
  } dist_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/nnt_city_store.sv =====
// ----------------------------------------------------------------------------
// nnt_city_store - city coordinate and id memory
// One write port for loading, one registered read port for the tour engine.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_city_store #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int COORD_W    = nnt_pkg::COORD_W,
  parameter int IW         = $clog2(MAX_CITIES)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [IW-1:0]           wr_addr,
  input  wire logic [nnt_pkg::ID_W-1:0] wr_id,
  input  wire logic [COORD_W-1:0]      wr_x,
  input  wire logic [COORD_W-1:0]      wr_y,
  input  wire logic [IW-1:0]           rd_addr,
  output logic      [nnt_pkg::ID_W-1:0] rd_id,
  output logic      [COORD_W-1:0]      rd_x,
  output logic      [COORD_W-1:0]      rd_y
);

  logic [nnt_pkg::ID_W-1:0] id_mem [MAX_CITIES];
  logic [COORD_W-1:0]       x_mem  [MAX_CITIES];
  logic [COORD_W-1:0]       y_mem  [MAX_CITIES];

  // Write on load, registered read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr] <= wr_id;
      x_mem[wr_addr]  <= wr_x;
      y_mem[wr_addr]  <= wr_y;
    end
    rd_id <= id_mem[rd_addr];
    rd_x  <= x_mem[rd_addr];
    rd_y  <= y_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/nnt_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nnt_dist_unit - squared distance unit
// Takes absolute differences, then squares dx and dy in turn on one shared
// multiplier. The sum of the two partials is the squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_dist_unit #(
  parameter int COORD_W = nnt_pkg::COORD_W,
  parameter int DW      = 2 * COORD_W + 1
) (
  input  wire logic                clk,
  input  wire nnt_pkg::dist_ctrl_t ctrl,
  input  wire logic [COORD_W-1:0]  rd_x,
  input  wire logic [COORD_W-1:0]  rd_y,
  input  wire logic [COORD_W-1:0]  cur_x,
  input  wire logic [COORD_W-1:0]  cur_y,
  output logic      [DW-1:0]       sq_dist
);

  logic [COORD_W-1:0]   dx;
  logic [COORD_W-1:0]   dy;
  logic [COORD_W-1:0]   mul_op;
  logic [2*COORD_W-1:0] prod;
  logic [2*COORD_W-1:0] sq_x;
  logic [2*COORD_W-1:0] sq_y;

  // Shared squarer: dx in the mul_x step, dy in the mul_y step
  assign mul_op = ctrl.mul_x ? dx : dy;
  assign prod   = mul_op * mul_op;

  always_ff @(posedge clk) begin
    if (ctrl.load_diff) begin
      dx <= (rd_x > cur_x) ? rd_x - cur_x : cur_x - rd_x;
      dy <= (rd_y > cur_y) ? rd_y - cur_y : cur_y - rd_y;
    end
    if (ctrl.mul_x) begin
      sq_x <= prod;
    end
    if (ctrl.mul_y) begin
      sq_y <= prod;
    end
  end

  assign sq_dist = DW'(sq_x) + DW'(sq_y);

endmodule

`default_nettype wire

// ===== rtl/nearest_neighbour_tour.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbour_tour - greedy nearest-neighbor tour engine
// Loads a city set, then emits the cities in nearest-neighbor tour order.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per city (id, x, y, last_city).
// Words without last_city are stored without holding off the next word. A word with
// last_city closes the set and starts the tour; in_ready stays low until the
// final tour word has been placed in the output register. Cities beyond
// MAX_CITIES are dropped, though their last_city flag still starts the tour.
// Output channel (out_valid/out_ready): one word per tour city, position 0
// being the first city loaded, tour_end on the last one.
// Each emitted word takes an id and coordinate fetch (S_ID_RD, S_ID_WAIT)
// and an output load (S_EMIT). Every step after the first adds a scan of
// all n entries, in which each unvisited candidate is read, its differences
// taken, dx and dy squared in turn on the single shared multiplier, and the
// sum compared; visited ones are skipped. A stalled receiver holds the
// engine at its next output load; the output register lets the last word
// wait while a new set is being loaded. Synchronous reset empties the set
// and the output register; the city memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_tour #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [nnt_pkg::ID_W-1:0]    city_id,
  input  wire logic [nnt_pkg::COORD_W-1:0] coord_x,
  input  wire logic [nnt_pkg::COORD_W-1:0] coord_y,
  input  wire logic                       last_city,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [nnt_pkg::ID_W-1:0]    tour_city_id,
  output logic      [nnt_pkg::POS_W-1:0]   tour_position,
  output logic                            tour_end
);

  localparam int CW   = (COORD_BITS < nnt_pkg::COORD_W) ? COORD_BITS : nnt_pkg::COORD_W;
  localparam int DW   = 2 * CW + 1;
  localparam int IW   = $clog2(MAX_CITIES);
  localparam int CNTW = $clog2(MAX_CITIES + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ID_RD   = 4'd1;
  localparam logic [3:0] S_ID_WAIT = 4'd2;
  localparam logic [3:0] S_EMIT    = 4'd3;
  localparam logic [3:0] S_SCAN    = 4'd4;
  localparam logic [3:0] S_DIFF    = 4'd5;
  localparam logic [3:0] S_MUL_X   = 4'd6;
  localparam logic [3:0] S_MUL_Y   = 4'd7;
  localparam logic [3:0] S_CMP     = 4'd8;

  logic [3:0]               state;
  logic [CNTW-1:0]          loaded_count;
  logic [CNTW-1:0]          n_cities;
  logic [CNTW-1:0]          tour_pos;
  logic [CNTW-1:0]          scan_idx;
  logic [IW-1:0]            emit_idx;
  logic [MAX_CITIES-1:0]    visited_mask;
  logic [IW-1:0]            best_index;
  logic [DW-1:0]            best_squared_distance;
  logic                     best_valid;
  logic [CW-1:0]            cur_x;
  logic [CW-1:0]            cur_y;
  logic [nnt_pkg::ID_W-1:0] id_hold;

  logic                     in_accept;
  logic                     wr_en;
  logic [IW-1:0]            rd_addr;
  logic [nnt_pkg::ID_W-1:0] rd_id;
  logic [CW-1:0]            rd_x;
  logic [CW-1:0]            rd_y;
  logic [DW-1:0]            sq_dist;
  logic                     out_free;
  logic                     out_load;
  logic                     pos_is_last;
  nnt_pkg::dist_ctrl_t      dctrl;

  // Handshake and memory port control
  assign in_ready    = (state == S_IDLE);
  assign in_accept   = in_valid && in_ready;
  assign wr_en       = in_accept && (loaded_count < CNTW'(MAX_CITIES));
  assign rd_addr     = (state == S_SCAN) ? scan_idx[IW-1:0] : emit_idx;
  assign out_free    = !out_valid || out_ready;
  assign out_load    = (state == S_EMIT) && out_free;
  assign pos_is_last = (CNTW'(tour_pos + 1'b1) == n_cities);

  always_comb begin
    dctrl.load_diff = (state == S_DIFF);
    dctrl.mul_x     = (state == S_MUL_X);
    dctrl.mul_y     = (state == S_MUL_Y);
  end

  nnt_city_store #(
    .MAX_CITIES (MAX_CITIES),
    .COORD_W    (CW),
    .IW         (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (loaded_count[IW-1:0]),
    .wr_id   (city_id),
    .wr_x    (coord_x[CW-1:0]),
    .wr_y    (coord_y[CW-1:0]),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  nnt_dist_unit #(
    .COORD_W (CW),
    .DW      (DW)
  ) u_dist (
    .clk     (clk),
    .ctrl    (dctrl),
    .rd_x    (rd_x),
    .rd_y    (rd_y),
    .cur_x   (cur_x),
    .cur_y   (cur_y),
    .sq_dist (sq_dist)
  );

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      loaded_count          <= '0;
      visited_mask          <= '0;
      best_index            <= '0;
      best_squared_distance <= '0;
      best_valid            <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (wr_en) begin
              loaded_count <= CNTW'(loaded_count + 1'b1);
            end
            if (last_city) begin
              n_cities     <= wr_en ? CNTW'(loaded_count + 1'b1) : loaded_count;
              visited_mask <= {{(MAX_CITIES-1){1'b0}}, 1'b1};
              tour_pos     <= '0;
              emit_idx     <= '0;
              state        <= S_ID_RD;
            end
          end
        end
        // Fetch id and coordinates of the chosen city
        S_ID_RD: begin
          state <= S_ID_WAIT;
        end
        S_ID_WAIT: begin
          cur_x   <= rd_x;
          cur_y   <= rd_y;
          id_hold <= rd_id;
          state   <= S_EMIT;
        end
        // Load the output register once it is free
        S_EMIT: begin
          if (out_free) begin
            tour_city_id  <= id_hold;
            tour_position <= nnt_pkg::POS_W'(tour_pos);
            tour_end      <= pos_is_last;
            if (pos_is_last) begin
              loaded_count <= '0;
              visited_mask <= '0;
              state        <= S_IDLE;
            end else begin
              tour_pos   <= CNTW'(tour_pos + 1'b1);
              scan_idx   <= '0;
              best_valid <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        // Walk the candidates; visited ones are skipped to the next index
        S_SCAN: begin
          if (scan_idx == n_cities) begin
            visited_mask[best_index] <= 1'b1;
            emit_idx <= best_index;
            state    <= S_ID_RD;
          end else if (visited_mask[scan_idx[IW-1:0]]) begin
            scan_idx <= CNTW'(scan_idx + 1'b1);
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= S_MUL_X;
        end
        S_MUL_X: begin
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          state <= S_CMP;
        end
        // Strictly smaller wins, so ties keep the lower index
        S_CMP: begin
          if (!best_valid || sq_dist < best_squared_distance) begin
            best_valid            <= 1'b1;
            best_squared_distance <= sq_dist;
            best_index            <= scan_idx[IW-1:0];
          end
          scan_idx <= CNTW'(scan_idx + 1'b1);
          state    <= S_SCAN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nnt_checker.sv =====
// ----------------------------------------------------------------------------
// nnt_checker - port-level checks for the nearest-neighbor tour block
// Watches the handshakes and the tour framing seen at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [nnt_pkg::ID_W-1:0]    city_id,
  input wire logic [nnt_pkg::COORD_W-1:0] coord_x,
  input wire logic [nnt_pkg::COORD_W-1:0] coord_y,
  input wire logic                       last_city,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [nnt_pkg::ID_W-1:0]    tour_city_id,
  input wire logic [nnt_pkg::POS_W-1:0]   tour_position,
  input wire logic                       tour_end
);

  // A waiting input word holds still
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(city_id) &&
      $stable(coord_x) && $stable(coord_y) && $stable(last_city))
    else $error("waiting input word changed");

  // A stalled result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tour_city_id) &&
      $stable(tour_position) && $stable(tour_end))
    else $error("stalled output word changed");

  // Closing a city set starts the tour, so input is blocked next cycle
  a_tour_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_city |=> !in_ready)
    else $error("input ready right after the last city");

  // While a tour is unfinished, no new city is taken
  a_busy_mid_tour: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !tour_end |-> !in_ready)
    else $error("input ready in the middle of a tour");

  // A tour does not restart at position 0 before its end word has been taken
  a_pos_after_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !tour_end |=> !out_valid || tour_position != '0)
    else $error("tour restarted before its end word");

endmodule

bind nearest_neighbour_tour nnt_checker u_nnt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .city_id       (city_id),
  .coord_x       (coord_x),
  .coord_y       (coord_y),
  .last_city     (last_city),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .tour_city_id  (tour_city_id),
  .tour_position (tour_position),
  .tour_end      (tour_end)
);

`default_nettype wire
